>>> hw/rtl/mfs_pkg.sv
// shared types and constants for the masked product frobenius sum block
`default_nettype none
package mfs_pkg;
   localparam int ELEM_W = 24;
   localparam int IDX_W  = 11;
   localparam int CFG_W  = 7;
   localparam int ACC_W  = 64;
   localparam int G_W    = 32;
   localparam int ROUND_SHIFT = 16;
   localparam logic [ACC_W-1:0] ACC_LIMIT = {1'b0, {(ACC_W-1){1'b1}}};

   typedef enum logic [1:0] {
      OP_LOAD_A = 2'd0,
      OP_LOAD_C = 2'd1,
      OP_LOAD_B = 2'd2,
      OP_START  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_ASSOC_ROWS = 2'd0,
      CSR_ASSOC_COLS = 2'd1,
      CSR_C_ROWS     = 2'd2,
      CSR_B_ROWS     = 2'd3
   } csr_index_type;

   // one step of the nested walk over the stores
   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last;
      logic [IDX_W-1:0] outer;
      logic [IDX_W-1:0] mid;
      logic [IDX_W-1:0] inner;
   } step_type;

   // element load toward the stores
   typedef struct packed {
      logic              a_we;
      logic              c_we;
      logic              b_we;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [ELEM_W-1:0] value;
   } load_type;
endpackage
`default_nettype wire

>>> hw/rtl/mfs_walk.sv
// nested three-level loop counter that drives store addresses
`default_nettype none
module mfs_walk (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [mfs_pkg::IDX_W-1:0] lim_outer,
   input  wire logic [mfs_pkg::IDX_W-1:0] lim_mid,
   input  wire logic [mfs_pkg::IDX_W-1:0] lim_inner,
   output mfs_pkg::step_type              step,
   output logic                           done
);
   import mfs_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [IDX_W-1:0] o_ff, o_in, m_ff, m_in, i_ff, i_in;
   logic             i_end, m_end, o_end;

   assign i_end = (i_ff == lim_inner - IDX_W'(1));
   assign m_end = (m_ff == lim_mid - IDX_W'(1));
   assign o_end = (o_ff == lim_outer - IDX_W'(1));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      o_in    = o_ff;
      m_in    = m_ff;
      i_in    = i_ff;
      if (start) begin
         o_in = '0;
         m_in = '0;
         i_in = '0;
         if (lim_outer == '0 || lim_mid == '0) begin
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (!i_end) begin
            i_in = i_ff + IDX_W'(1);
         end else begin
            i_in = '0;
            if (!m_end) begin
               m_in = m_ff + IDX_W'(1);
            end else begin
               m_in = '0;
               if (!o_end) begin
                  o_in = o_ff + IDX_W'(1);
               end else begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         o_ff    <= '0;
         m_ff    <= '0;
         i_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         o_ff    <= o_in;
         m_ff    <= m_in;
         i_ff    <= i_in;
      end
   end

   assign step.valid = busy_ff;
   assign step.first = (i_ff == '0);
   assign step.last  = i_end;
   assign step.outer = o_ff;
   assign step.mid   = m_ff;
   assign step.inner = i_ff;
   assign done       = done_ff;
endmodule
`default_nettype wire

>>> hw/rtl/mfs_core.sv
// stores and the read-modify-write datapath for both product passes
`default_nettype none
module mfs_core #(
   parameter int MAX_ASSOC_ROWS = 64,
   parameter int MAX_ASSOC_COLS = 64,
   parameter int MAX_C_ROWS     = 64,
   parameter int MAX_B_ROWS     = 64
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  mfs_pkg::load_type              load,
   input  mfs_pkg::step_type              step,
   input  wire logic                      phase,      // 0 partial pass, 1 product pass
   input  wire logic                      use_inner,  // inner dimension nonzero
   input  wire logic                      clear_acc,
   output logic [mfs_pkg::ACC_W-1:0]      acc,
   output logic                           overflowed
);
   import mfs_pkg::*;

   localparam int AR_W = (MAX_ASSOC_ROWS > 1) ? $clog2(MAX_ASSOC_ROWS) : 1;
   localparam int AC_W = (MAX_ASSOC_COLS > 1) ? $clog2(MAX_ASSOC_COLS) : 1;
   localparam int CR_W = (MAX_C_ROWS > 1) ? $clog2(MAX_C_ROWS) : 1;
   localparam int BR_W = (MAX_B_ROWS > 1) ? $clog2(MAX_B_ROWS) : 1;
   localparam int A_DEPTH = MAX_ASSOC_ROWS * (1 << AC_W);
   localparam int C_DEPTH = MAX_C_ROWS * (1 << AC_W);
   localparam int B_DEPTH = MAX_B_ROWS * (1 << AR_W);
   localparam int P_DEPTH = MAX_C_ROWS * (1 << AR_W);
   localparam int PW = ELEM_W + $clog2(MAX_ASSOC_COLS + 1);
   localparam int PROD_W = PW + ELEM_W;

   logic              a_mem [A_DEPTH];
   logic [ELEM_W-1:0] c_mem [C_DEPTH];
   logic [ELEM_W-1:0] b_mem [B_DEPTH];
   logic [PW-1:0]     p_mem [P_DEPTH];

   logic              a_q;
   logic [ELEM_W-1:0] c_q, b_q;
   logic [PW-1:0]     p_q;

   logic row_ok_a, col_ok_a, row_ok_c, row_ok_b, col_ok_b;
   assign row_ok_a = load.row < IDX_W'(MAX_ASSOC_ROWS);
   assign col_ok_a = load.col < IDX_W'(MAX_ASSOC_COLS);
   assign row_ok_c = load.row < IDX_W'(MAX_C_ROWS);
   assign row_ok_b = load.row < IDX_W'(MAX_B_ROWS);
   assign col_ok_b = load.col < IDX_W'(MAX_ASSOC_ROWS);

   // read addresses from the walk: partial pass (i, j, k), product pass (j, l, i)
   logic [AR_W+AC_W-1:0] a_raddr;
   logic [CR_W+AC_W-1:0] c_raddr;
   logic [BR_W+AR_W-1:0] b_raddr;
   logic [CR_W+AR_W-1:0] p_raddr;
   assign a_raddr = {step.outer[AR_W-1:0], step.inner[AC_W-1:0]};
   assign c_raddr = {step.mid[CR_W-1:0], step.inner[AC_W-1:0]};
   assign b_raddr = {step.mid[BR_W-1:0], step.inner[AR_W-1:0]};
   assign p_raddr = {step.outer[CR_W-1:0], step.inner[AR_W-1:0]};

   always_ff @(posedge clock) begin
      if (load.a_we && row_ok_a && col_ok_a) begin
         a_mem[{load.row[AR_W-1:0], load.col[AC_W-1:0]}] <= (load.value != '0);
      end
      a_q <= a_mem[a_raddr];
   end

   always_ff @(posedge clock) begin
      if (load.c_we && row_ok_c && col_ok_a) begin
         c_mem[{load.row[CR_W-1:0], load.col[AC_W-1:0]}] <= load.value;
      end
      c_q <= c_mem[c_raddr];
   end

   always_ff @(posedge clock) begin
      if (load.b_we && row_ok_b && col_ok_b) begin
         b_mem[{load.row[BR_W-1:0], load.col[AR_W-1:0]}] <= load.value;
      end
      b_q <= b_mem[b_raddr];
   end

   // stage 1: read data valid
   logic            v1_ff, first1_ff, last1_ff;
   logic [AR_W-1:0] i1_ff;
   logic [CR_W-1:0] j1_ff;
   logic [PW-1:0]   t_ff, t_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= step.valid;
      end
      first1_ff <= step.first;
      last1_ff  <= step.last;
      i1_ff     <= step.outer[AR_W-1:0];
      j1_ff     <= step.mid[CR_W-1:0];
   end

   assign t_in = (first1_ff ? '0 : t_ff)
               + ((a_q && use_inner) ? {{(PW-ELEM_W){c_q[ELEM_W-1]}}, c_q} : '0);

   always_ff @(posedge clock) begin
      if (v1_ff && !phase) begin
         t_ff <= t_in;
      end
      if (v1_ff && last1_ff && !phase) begin
         p_mem[{j1_ff, i1_ff}] <= t_in;
      end
      p_q <= p_mem[p_raddr];
   end

   // stage 2: product
   logic                     v2_ff, first2_ff, last2_ff;
   logic signed [PROD_W-1:0] prod_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff && phase;
      end
      first2_ff <= first1_ff;
      last2_ff  <= last1_ff;
      prod_ff   <= use_inner ? PROD_W'($signed(p_q) * $signed(b_q)) : '0;
   end

   // stage 3: saturating dot-product sum
   logic signed [ACC_W-1:0] s_ff, sdone_ff;
   logic signed [ACC_W:0]   s_wide;
   logic signed [ACC_W-1:0] s_in;
   logic                    v3_ff;
   assign s_wide = (first2_ff ? '0 : {s_ff[ACC_W-1], s_ff})
                 + {{(ACC_W+1-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   always_comb begin
      if (s_wide[ACC_W] != s_wide[ACC_W-1]) begin
         s_in = s_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         s_in = s_wide[ACC_W-1:0];
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff && last2_ff;
      end
      if (v2_ff) begin
         s_ff <= s_in;
      end
      if (v2_ff && last2_ff) begin
         sdone_ff <= s_in;
      end
   end

   // stage 4: round half up to q8.24, clamp to 32 bits, magnitude
   logic signed [ACC_W:0]             y;
   logic signed [ACC_W-ROUND_SHIFT:0] q;
   logic signed [G_W-1:0]             g;
   logic [G_W-1:0]                    gmag_ff;
   logic                              v4_ff;
   assign y = {sdone_ff[ACC_W-1], sdone_ff} + (ACC_W+1)'(1 << (ROUND_SHIFT - 1));
   assign q = y[ACC_W:ROUND_SHIFT];
   always_comb begin
      if (q > (ACC_W-ROUND_SHIFT+1)'(32'sh7FFF_FFFF)) begin
         g = 32'sh7FFF_FFFF;
      end else if (q < -(ACC_W-ROUND_SHIFT+1)'(33'sh0_8000_0000)) begin
         g = 32'sh8000_0000;
      end else begin
         g = q[G_W-1:0];
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      gmag_ff <= g[G_W-1] ? G_W'(-g) : G_W'(g);
   end

   // stage 5: square
   logic [ACC_W-1:0] sq_ff;
   logic             v5_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      sq_ff <= gmag_ff * gmag_ff;
   end

   // stage 6: saturating accumulate
   logic [ACC_W-1:0] acc_ff;
   logic             ovf_ff;
   logic [ACC_W:0]   acc_sum;
   assign acc_sum = {1'b0, acc_ff} + {1'b0, sq_ff};
   always_ff @(posedge clock) begin
      if (reset || clear_acc) begin
         acc_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (v5_ff) begin
         if (acc_sum > {1'b0, ACC_LIMIT}) begin
            acc_ff <= ACC_LIMIT;
            ovf_ff <= 1'b1;
         end else begin
            acc_ff <= acc_sum[ACC_W-1:0];
         end
      end
   end

   assign acc        = acc_ff;
   assign overflowed = ovf_ff;
endmodule
`default_nettype wire

>>> hw/rtl/masked_product_frobenius_sum.sv
// top level: stream ports, register file and pass sequencing
//
//  channel | dir | fields (low bit first)
//  req_    | in  | tdata: opcode[1:0] row_index[7:2] col_index[13:8] value[37:14]
//  rsp_    | out | tdata: statistic[62:0] overflowed[63]
//  csr_    | in  | wen, index[1:0], data[6:0]
//
// a load is taken while the block is idle; the next item is taken in the following cycle.
// a start walks n1*n3*max(n2,1) entries, then n3*n4*max(n1,1), one a cycle from the
// single read port of each store, plus the start and done steps and two drain waits.
// reset is synchronous; store contents are not cleared.
// a result waiting on rsp_ does not stop loads; a following start runs and holds its
// result until rsp_ is free.
`default_nettype none
module masked_product_frobenius_sum #(
   parameter int MAX_ASSOC_ROWS = 64,
   parameter int MAX_ASSOC_COLS = 64,
   parameter int MAX_C_ROWS     = 64,
   parameter int MAX_B_ROWS     = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // opcode, row_index, col_index, value
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // statistic, overflowed
   input  wire logic        csr_wen,
   input  wire logic [1:0]  csr_index,
   input  wire logic [6:0]  csr_data
);
   import mfs_pkg::*;

   localparam int DRAIN = 8;

   typedef enum logic [2:0] {
      S_IDLE, S_RUN1, S_WAIT1, S_RUN2, S_WAIT2, S_DONE
   } state_type;

   state_type        state_ff;
   logic [3:0]       cnt_ff;
   logic             start_ff, phase_ff, clear_ff;
   logic             rsp_valid_ff;
   logic [63:0]      rsp_data_ff;
   logic [CFG_W-1:0] ar_ff, ac_ff, cr_ff, br_ff;

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ar_ff <= CFG_W'(64);
         ac_ff <= CFG_W'(64);
         cr_ff <= CFG_W'(64);
         br_ff <= CFG_W'(64);
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_ASSOC_ROWS: ar_ff <= csr_data;
            CSR_ASSOC_COLS: ac_ff <= csr_data;
            CSR_C_ROWS:     cr_ff <= csr_data;
            CSR_B_ROWS:     br_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic [IDX_W-1:0] n1, n2, n3, n4, n1_ext, n2_ext, n3_ext, n4_ext;
   assign n1_ext = IDX_W'(ar_ff);
   assign n2_ext = IDX_W'(ac_ff);
   assign n3_ext = IDX_W'(cr_ff);
   assign n4_ext = IDX_W'(br_ff);
   assign n1 = (n1_ext > IDX_W'(MAX_ASSOC_ROWS)) ? IDX_W'(MAX_ASSOC_ROWS) : n1_ext;
   assign n2 = (n2_ext > IDX_W'(MAX_ASSOC_COLS)) ? IDX_W'(MAX_ASSOC_COLS) : n2_ext;
   assign n3 = (n3_ext > IDX_W'(MAX_C_ROWS)) ? IDX_W'(MAX_C_ROWS) : n3_ext;
   assign n4 = (n4_ext > IDX_W'(MAX_B_ROWS)) ? IDX_W'(MAX_B_ROWS) : n4_ext;

   // input decode
   op_type   op;
   logic     req_fire;
   logic     start_fire;
   load_type load;
   assign op         = op_type'(req_tdata[1:0]);
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign start_fire = req_fire && (op == OP_START);
   assign load.a_we  = req_fire && (op == OP_LOAD_A);
   assign load.c_we  = req_fire && (op == OP_LOAD_C);
   assign load.b_we  = req_fire && (op == OP_LOAD_B);
   assign load.row   = IDX_W'(req_tdata[7:2]);
   assign load.col   = IDX_W'(req_tdata[13:8]);
   assign load.value = req_tdata[37:14];

   // walk limits per pass
   logic [IDX_W-1:0] lim_o, lim_m, lim_i;
   logic             use_inner;
   assign lim_o     = phase_ff ? n3 : n1;
   assign lim_m     = phase_ff ? n4 : n3;
   assign lim_i     = phase_ff ? ((n1 == '0) ? IDX_W'(1) : n1)
                               : ((n2 == '0) ? IDX_W'(1) : n2);
   assign use_inner = phase_ff ? (n1 != '0) : (n2 != '0);

   step_type         step;
   logic             walk_done;
   logic [ACC_W-1:0] acc;
   logic             ovf;

   mfs_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .start     (start_ff),
      .lim_outer (lim_o),
      .lim_mid   (lim_m),
      .lim_inner (lim_i),
      .step      (step),
      .done      (walk_done)
   );

   mfs_core #(
      .MAX_ASSOC_ROWS (MAX_ASSOC_ROWS),
      .MAX_ASSOC_COLS (MAX_ASSOC_COLS),
      .MAX_C_ROWS     (MAX_C_ROWS),
      .MAX_B_ROWS     (MAX_B_ROWS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .step       (step),
      .phase      (phase_ff),
      .use_inner  (use_inner),
      .clear_acc  (clear_ff),
      .acc        (acc),
      .overflowed (ovf)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         start_ff     <= 1'b0;
         phase_ff     <= 1'b0;
         clear_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= ((state_ff == S_IDLE) && start_fire)
                  || ((state_ff == S_WAIT1) && (cnt_ff == 4'(DRAIN - 1)));
         clear_ff <= (state_ff == S_IDLE) && start_fire;
         // output register free or being emptied this cycle
         if ((state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (start_fire) begin
                  state_ff <= S_RUN1;
                  phase_ff <= 1'b0;
               end
            end
            S_RUN1: begin
               if (walk_done) begin
                  state_ff <= S_WAIT1;
                  cnt_ff   <= '0;
               end
            end
            S_WAIT1: begin
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'(DRAIN - 1)) begin
                  state_ff <= S_RUN2;
                  phase_ff <= 1'b1;
               end
            end
            S_RUN2: begin
               if (walk_done) begin
                  state_ff <= S_WAIT2;
                  cnt_ff   <= '0;
               end
            end
            S_WAIT2: begin
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'(DRAIN - 1)) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_data_ff  <= {ovf, acc[ACC_W-2:0]};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
endmodule
`default_nettype wire
